@@ hdl/plws_pkg.sv @@
// Shared types and constants for the persistent lattice walker step unit.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
package plws_pkg;

  // Field widths fixed by the walker's item layout
  localparam int POS_W   = 10;
  localparam int SIDE_W  = 11;
  localparam int PROB_W  = 17;
  localparam int DRAW_W  = 16;
  localparam int HEAD_W  = 2;
  localparam int MODE_W  = 2;
  localparam int RAD_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int OUT_CNT_W  = 32;

  // One as an unsigned 1.16 fraction
  localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

  // Operation codes
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  // Headings
  localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd2;
  localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd3;

  // Boundary modes
  localparam logic [MODE_W-1:0] MODE_FROZEN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ABSORB   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INERT    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_PROB  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFLECT_PROB  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LATTICE_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_RADIUS = 3'd6;

  // Input beat
  typedef struct packed {
    logic              operation;
    logic [DRAW_W-1:0] move_draw;
    logic              turn_coin;
    logic [DRAW_W-1:0] wall_draw;
    logic [POS_W-1:0]  place_x;
    logic [POS_W-1:0]  place_y;
    logic [HEAD_W-1:0] place_heading;
  } item_t;

  // Output beat
  typedef struct packed {
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [HEAD_W-1:0]    heading;
    logic                 target_found;
    logic                 absorbed_now;
    logic                 place_rejected;
    logic [OUT_CNT_W-1:0] wall_visits;
    logic [OUT_CNT_W-1:0] absorptions;
  } result_t;

  // Configuration as held in the top level; back_edge is derived on write
  typedef struct packed {
    logic [PROB_W-1:0] forward_prob;
    logic [PROB_W-1:0] back_edge;
    logic [PROB_W-1:0] reflect_prob;
    logic [SIDE_W-1:0] lattice_size;
    logic [MODE_W-1:0] boundary_mode;
    logic [POS_W-1:0]  target_x;
    logic [POS_W-1:0]  target_y;
    logic [RAD_W-1:0]  detect_radius;
  } cfg_t;

  // Walker position and heading
  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [HEAD_W-1:0] heading;
  } walker_t;

  // Per-item status from the step logic
  typedef struct packed {
    logic found;
    logic absorbed;
    logic rejected;
    logic reflected;
  } step_flags_t;

endpackage

@@ hdl/plws_item_if.sv @@
// Valid/ready channel carrying one walker input beat.
// Depends on plws_pkg for the item_t payload.
interface plws_item_if;
  logic            valid;
  logic            ready;
  plws_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/plws_result_if.sv @@
// Valid/ready channel carrying one walker result beat.
// Depends on plws_pkg for the result_t payload.
interface plws_result_if;
  logic              valid;
  logic              ready;
  plws_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/persistent_lattice_walker_step_unit.sv @@
// Persistent lattice walker step unit: top level with configuration
// registers, walker state, saturating counters and a two-beat output buffer.
// Throughput: one item per cycle while the skid slot is empty; the walker
// update is a single pass through plws_step_logic and each result is
// registered. Two output slots keep input open while one result waits.
// Reset (rst, synchronous): walker at (0,0) heading right, counters zero,
// registers to their defaults, output buffer empty. Depends on plws_pkg.
module persistent_lattice_walker_step_unit #(
  parameter int MAX_SIDE   = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [plws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [plws_pkg::CFG_DATA_W-1:0]   cfg_data,
  plws_item_if.sink                         items,
  plws_result_if.source                     results
);

  plws_pkg::cfg_t        cfg;
  plws_pkg::walker_t     walker;
  plws_pkg::walker_t     walker_next;
  plws_pkg::step_flags_t flags;
  logic [COUNT_BITS-1:0] reflection_count;
  logic [COUNT_BITS-1:0] absorption_count;
  logic [COUNT_BITS-1:0] reflection_count_next;
  logic [COUNT_BITS-1:0] absorption_count_next;
  logic [63:0]           refl_wide;
  logic [63:0]           abs_wide;
  plws_pkg::result_t     result_next;
  plws_pkg::result_t     out_reg;
  plws_pkg::result_t     skid_reg;
  logic                  out_valid;
  logic                  skid_valid;
  logic                  in_fire;
  logic                  out_free;
  logic [16:0]           pf_w;
  logic [16:0]           rem_w;
  logic [32:0]           third_prod;
  logic [16:0]           back_edge_w;

  // Clamp a written forward probability and derive the back-move edge:
  // (65536 - pf) / 3 as a multiply by ceil(2^17 / 3), exact over 17 bits
  always_comb begin
    pf_w = (cfg_data > plws_pkg::PROB_ONE) ? plws_pkg::PROB_ONE : cfg_data;
    rem_w = plws_pkg::PROB_ONE - pf_w;
    third_prod = {16'd0, rem_w} * 33'd43691;
    back_edge_w = pf_w + {1'b0, third_prod[32:17]};
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.forward_prob  <= 17'd32768;
      cfg.back_edge     <= 17'd43690;
      cfg.reflect_prob  <= 17'd32768;
      cfg.lattice_size  <= 11'd64;
      cfg.boundary_mode <= plws_pkg::MODE_PERIODIC;
      cfg.target_x      <= '0;
      cfg.target_y      <= '0;
      cfg.detect_radius <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        plws_pkg::REG_FORWARD_PROB: begin
          cfg.forward_prob <= pf_w;
          cfg.back_edge    <= back_edge_w;
        end
        plws_pkg::REG_REFLECT_PROB:  cfg.reflect_prob  <= cfg_data;
        plws_pkg::REG_LATTICE_SIZE:  cfg.lattice_size  <= cfg_data[10:0];
        plws_pkg::REG_BOUNDARY_MODE: cfg.boundary_mode <= cfg_data[1:0];
        plws_pkg::REG_TARGET_X:      cfg.target_x      <= cfg_data[9:0];
        plws_pkg::REG_TARGET_Y:      cfg.target_y      <= cfg_data[9:0];
        plws_pkg::REG_DETECT_RADIUS: cfg.detect_radius <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  plws_step_logic #(
    .MAX_SIDE (MAX_SIDE)
  ) u_step (
    .cfg         (cfg),
    .walker      (walker),
    .item        (items.data),
    .walker_next (walker_next),
    .flags       (flags)
  );

  // Saturating counter updates
  always_comb begin
    reflection_count_next = reflection_count;
    absorption_count_next = absorption_count;
    if (flags.reflected && (reflection_count != '1)) begin
      reflection_count_next = reflection_count + COUNT_BITS'(1);
    end
    if (flags.absorbed && (absorption_count != '1)) begin
      absorption_count_next = absorption_count + COUNT_BITS'(1);
    end
    refl_wide = 64'(reflection_count_next);
    abs_wide  = 64'(absorption_count_next);
  end

  // Assemble the result beat
  always_comb begin
    result_next.pos_x          = walker_next.x;
    result_next.pos_y          = walker_next.y;
    result_next.heading        = walker_next.heading;
    result_next.target_found   = flags.found;
    result_next.absorbed_now   = flags.absorbed;
    result_next.place_rejected = flags.rejected;
    result_next.wall_visits    = refl_wide[plws_pkg::OUT_CNT_W-1:0];
    result_next.absorptions    = abs_wide[plws_pkg::OUT_CNT_W-1:0];
  end

  // Handshake: take input while the skid slot is empty
  assign items.ready   = !skid_valid;
  assign in_fire       = items.valid && !skid_valid;
  assign out_free      = !out_valid || results.ready;
  assign results.valid = out_valid;
  assign results.data  = out_reg;

  // Advance walker state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      walker           <= '0;
      reflection_count <= '0;
      absorption_count <= '0;
    end else if (in_fire) begin
      walker           <= walker_next;
      reflection_count <= reflection_count_next;
      absorption_count <= absorption_count_next;
    end
  end

  // Output register plus skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves: no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (in_fire) begin
        out_reg <= result_next;
      end
    end else if (in_fire) begin
      skid_reg <= result_next;
    end
  end

endmodule

@@ hdl/plws_step_logic.sv @@
// Combinational next-state logic for one walker item: heading pick, move,
// wrap, wall reflect/absorb, place and target detection. Depends on plws_pkg.
module plws_step_logic #(
  parameter int MAX_SIDE = 1024
) (
  input  plws_pkg::cfg_t        cfg,
  input  plws_pkg::walker_t     walker,
  input  plws_pkg::item_t       item,
  output plws_pkg::walker_t     walker_next,
  output plws_pkg::step_flags_t flags
);

  localparam logic [16:0] MAX_SIDE_V = 17'(MAX_SIDE);

  logic [plws_pkg::SIDE_W-1:0] side;
  logic [plws_pkg::SIDE_W-1:0] side_m1;
  logic [plws_pkg::HEAD_W-1:0] pick;
  logic signed [12:0]          dx;
  logic signed [12:0]          dy;
  logic signed [12:0]          mx;
  logic signed [12:0]          my;
  logic signed [12:0]          side_s;
  logic [plws_pkg::POS_W-1:0]  free_x;
  logic [plws_pkg::POS_W-1:0]  free_y;
  logic [plws_pkg::POS_W-1:0]  wrap_x;
  logic [plws_pkg::POS_W-1:0]  wrap_y;
  logic                        on_left;
  logic                        on_right;
  logic                        on_bottom;
  logic                        on_top;
  logic                        bounce;
  logic                        corner;
  logic [plws_pkg::POS_W-1:0]  diff_x;
  logic [plws_pkg::POS_W-1:0]  diff_y;
  logic [plws_pkg::RAD_W-1:0]  manhattan;
  logic                        found;
  logic                        absorbed;
  logic                        rejected;
  logic                        reflected;

  // Clamp the side length to [2, MAX_SIDE]
  always_comb begin
    if (cfg.lattice_size < 11'd2) begin
      side = 11'd2;
    end else if ({6'd0, cfg.lattice_size} > MAX_SIDE_V) begin
      side = MAX_SIDE_V[plws_pkg::SIDE_W-1:0];
    end else begin
      side = cfg.lattice_size;
    end
    side_m1 = side - 11'd1;
    side_s  = $signed({2'b00, side});
  end

  // Pick straight, back or a turn from the move draw
  always_comb begin
    if ({1'b0, item.move_draw} < cfg.forward_prob) begin
      pick = walker.heading;
    end else if ({1'b0, item.move_draw} < cfg.back_edge) begin
      pick = walker.heading + 2'd2;
    end else if (item.turn_coin) begin
      pick = walker.heading + 2'd3;
    end else begin
      pick = walker.heading + 2'd1;
    end
  end

  // Unit step along the picked heading, then the periodic wrap
  always_comb begin
    dx = '0;
    dy = '0;
    case (pick)
      plws_pkg::HEAD_RIGHT: dx = 13'sd1;
      plws_pkg::HEAD_UP:    dy = 13'sd1;
      plws_pkg::HEAD_LEFT:  dx = -13'sd1;
      plws_pkg::HEAD_DOWN:  dy = -13'sd1;
      default:              dx = '0;
    endcase
    mx = $signed({3'b000, walker.x}) + dx;
    my = $signed({3'b000, walker.y}) + dy;
    free_x = mx[plws_pkg::POS_W-1:0];
    free_y = my[plws_pkg::POS_W-1:0];
    if (mx < 0) begin
      wrap_x = 10'(mx + side_s);
    end else if (mx >= side_s) begin
      wrap_x = 10'(mx - side_s);
    end else begin
      wrap_x = free_x;
    end
    if (my < 0) begin
      wrap_y = 10'(my + side_s);
    end else if (my >= side_s) begin
      wrap_y = 10'(my - side_s);
    end else begin
      wrap_y = free_y;
    end
  end

  // Wall tests on the current walker and on the place coordinates
  always_comb begin
    on_left   = (walker.x == '0);
    on_right  = ({1'b0, walker.x} == side_m1);
    on_bottom = (walker.y == '0);
    on_top    = ({1'b0, walker.y} == side_m1);
    bounce    = ({1'b0, item.wall_draw} < cfg.reflect_prob);
    corner    = ((item.place_x == '0) || ({1'b0, item.place_x} == side_m1)) &&
                ((item.place_y == '0) || ({1'b0, item.place_y} == side_m1));
  end

  // Select the next walker state
  always_comb begin
    walker_next = walker;
    absorbed    = 1'b0;
    reflected   = 1'b0;
    if (item.operation == plws_pkg::OP_PLACE) begin
      walker_next.x       = item.place_x;
      walker_next.y       = item.place_y;
      walker_next.heading = item.place_heading;
    end else if (cfg.boundary_mode == plws_pkg::MODE_PERIODIC) begin
      walker_next.x       = wrap_x;
      walker_next.y       = wrap_y;
      walker_next.heading = pick;
    end else if (cfg.boundary_mode == plws_pkg::MODE_ABSORB) begin
      if (!(on_left || on_right || on_bottom || on_top)) begin
        walker_next.x       = free_x;
        walker_next.y       = free_y;
        walker_next.heading = pick;
      end else if (!bounce) begin
        absorbed = 1'b1;
      end else begin
        reflected = 1'b1;
        if (on_left) begin
          walker_next.x       = walker.x + 10'd1;
          walker_next.heading = plws_pkg::HEAD_RIGHT;
        end else if (on_right) begin
          walker_next.x       = walker.x - 10'd1;
          walker_next.heading = plws_pkg::HEAD_LEFT;
        end else if (on_bottom) begin
          walker_next.y       = walker.y + 10'd1;
          walker_next.heading = plws_pkg::HEAD_UP;
        end else begin
          walker_next.y       = walker.y - 10'd1;
          walker_next.heading = plws_pkg::HEAD_DOWN;
        end
      end
    end
  end

  // Manhattan distance of the new position to the target
  always_comb begin
    diff_x = (walker_next.x >= cfg.target_x) ? walker_next.x - cfg.target_x
                                             : cfg.target_x - walker_next.x;
    diff_y = (walker_next.y >= cfg.target_y) ? walker_next.y - cfg.target_y
                                             : cfg.target_y - walker_next.y;
    manhattan = {1'b0, diff_x} + {1'b0, diff_y};
    found     = (manhattan <= cfg.detect_radius);
    rejected  = (item.operation == plws_pkg::OP_PLACE) &&
                (found ||
                 ((cfg.boundary_mode == plws_pkg::MODE_ABSORB) && corner));
  end

  // Pack the per-item status
  assign flags = {found, absorbed, rejected, reflected};

endmodule

@@ bench/persistent_lattice_walker_step_unit_test.sv @@
// Self-checking bench for the persistent lattice walker step unit: directed and random
// step/place beats, checked against a cycle-free walker predictor under varied idling.
// Depends on plws_pkg, plws_item_if, plws_result_if and the unit's RTL.
`timescale 1ns / 1ps

module persistent_lattice_walker_step_unit_test;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [plws_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [plws_pkg::CFG_DATA_W-1:0] cfg_data;

  plws_item_if items_ch ();
  plws_result_if results_ch ();

  persistent_lattice_walker_step_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_ch),
    .results   (results_ch)
  );

  // Register shadows as the walker sees them
  logic [plws_pkg::PROB_W-1:0] fwd_prob;
  logic [plws_pkg::PROB_W-1:0] refl_prob;
  logic [plws_pkg::SIDE_W-1:0] lat_size;
  logic [plws_pkg::MODE_W-1:0] bmode;
  logic [plws_pkg::POS_W-1:0]  tgt_x;
  logic [plws_pkg::POS_W-1:0]  tgt_y;
  logic [plws_pkg::RAD_W-1:0]  radius;

  // Walker state as predicted
  logic [plws_pkg::POS_W-1:0]     wk_x;
  logic [plws_pkg::POS_W-1:0]     wk_y;
  logic [plws_pkg::HEAD_W-1:0]    wk_head;
  logic [plws_pkg::OUT_CNT_W-1:0] bounce_count;
  logic [plws_pkg::OUT_CNT_W-1:0] stuck_count;

  plws_pkg::item_t   pending_items[$];
  plws_pkg::result_t expected_results[$];

  int items_queued;
  int results_checked;
  int mismatch_count;
  int send_idle_pct;
  int stall_pct;
  int cycle_count;
  int setups_done;
  int rejects_seen;
  int absorbs_seen;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int side_len();
    int s;
    s = int'(lat_size);
    if (s < 2) s = 2;
    if (s > 1024) s = 1024;
    return s;
  endfunction

  function automatic int forward_limit();
    return (fwd_prob > plws_pkg::PROB_ONE) ? int'(plws_pkg::PROB_ONE) : int'(fwd_prob);
  endfunction

  function automatic int back_limit();
    return forward_limit() + (65536 - forward_limit()) / 3;
  endfunction

  function automatic bit near_target(logic [plws_pkg::POS_W-1:0] x,
                                     logic [plws_pkg::POS_W-1:0] y);
    int dx;
    int dy;
    dx = int'(x) - int'(tgt_x);
    dy = int'(y) - int'(tgt_y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx + dy) <= int'(radius);
  endfunction

  // Pick a heading from the draw and move one cell, wrapping once when periodic
  function automatic void roam(plws_pkg::item_t it, bit wrap);
    int x;
    int y;
    int side;
    int draw;
    logic [plws_pkg::HEAD_W-1:0] h;
    x = int'(wk_x);
    y = int'(wk_y);
    side = side_len();
    draw = int'(it.move_draw);
    if (draw < forward_limit()) h = wk_head;
    else if (draw < back_limit()) h = wk_head + 2'd2;
    else if (it.turn_coin) h = wk_head - 2'd1;
    else h = wk_head + 2'd1;
    case (h)
      plws_pkg::HEAD_RIGHT: x = x + 1;
      plws_pkg::HEAD_UP:    y = y + 1;
      plws_pkg::HEAD_LEFT:  x = x - 1;
      default:              y = y - 1;
    endcase
    if (wrap) begin
      if (x < 0) x = x + side;
      else if (x >= side) x = x - side;
      if (y < 0) y = y + side;
      else if (y >= side) y = y - side;
    end
    wk_head = h;
    wk_x = x[plws_pkg::POS_W-1:0];
    wk_y = y[plws_pkg::POS_W-1:0];
  endfunction

  // Advance the predicted walker by one beat and return the result it should report
  function automatic plws_pkg::result_t advance_walker(plws_pkg::item_t it);
    plws_pkg::result_t r;
    int last;
    logic [plws_pkg::POS_W-1:0] nx;
    logic [plws_pkg::POS_W-1:0] ny;
    logic [plws_pkg::HEAD_W-1:0] nh;
    bit on_wall;
    bit absorbed;
    bit rejected;
    last = side_len() - 1;
    absorbed = 1'b0;
    rejected = 1'b0;
    if (it.operation == plws_pkg::OP_PLACE) begin
      wk_x = it.place_x;
      wk_y = it.place_y;
      wk_head = it.place_heading;
      rejected = near_target(wk_x, wk_y);
      if (bmode == plws_pkg::MODE_ABSORB && (wk_x == 0 || wk_x == last) &&
          (wk_y == 0 || wk_y == last))
        rejected = 1'b1;
    end else if (bmode == plws_pkg::MODE_PERIODIC) begin
      roam(it, 1'b1);
    end else if (bmode == plws_pkg::MODE_ABSORB) begin
      nx = wk_x;
      ny = wk_y;
      nh = wk_head;
      on_wall = 1'b1;
      // Left wall wins over right, then bottom, then top
      if (wk_x == 0) begin
        nx = wk_x + 10'd1;
        nh = plws_pkg::HEAD_RIGHT;
      end else if (wk_x == last) begin
        nx = wk_x - 10'd1;
        nh = plws_pkg::HEAD_LEFT;
      end else if (wk_y == 0) begin
        ny = wk_y + 10'd1;
        nh = plws_pkg::HEAD_UP;
      end else if (wk_y == last) begin
        ny = wk_y - 10'd1;
        nh = plws_pkg::HEAD_DOWN;
      end else begin
        on_wall = 1'b0;
      end
      if (!on_wall) begin
        roam(it, 1'b0);
      end else if ({1'b0, it.wall_draw} < refl_prob) begin
        wk_x = nx;
        wk_y = ny;
        wk_head = nh;
        if (bounce_count != '1) bounce_count = bounce_count + 32'd1;
      end else begin
        absorbed = 1'b1;
        if (stuck_count != '1) stuck_count = stuck_count + 32'd1;
      end
    end
    r.pos_x = wk_x;
    r.pos_y = wk_y;
    r.heading = wk_head;
    r.target_found = near_target(wk_x, wk_y);
    r.absorbed_now = absorbed;
    r.place_rejected = rejected;
    r.wall_visits = bounce_count;
    r.absorptions = stuck_count;
    return r;
  endfunction

  function automatic void flag_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on result %0d, %s: expected %0d, got %0d",
                 results_checked, field, want, got);
    end
  endfunction

  // Drive input beats from the pending queue, predicting each one as it is taken
  always @(posedge clk) begin : feed_items
    plws_pkg::item_t nxt;
    bit hold_off;
    if (rst) begin
      items_ch.valid <= 1'b0;
    end else begin
      if (items_ch.valid && items_ch.ready)
        expected_results.push_back(advance_walker(items_ch.data));
      if (!items_ch.valid || items_ch.ready) begin
        hold_off = ($urandom_range(0, 99) < send_idle_pct);
        if (pending_items.size() != 0 && !hold_off) begin
          nxt = pending_items.pop_front();
          items_ch.data <= nxt;
          items_ch.valid <= 1'b1;
        end else begin
          items_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Take result beats and check them against the oldest prediction
  always @(posedge clk) begin : check_results
    plws_pkg::result_t want;
    plws_pkg::result_t got;
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        got = results_ch.data;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: x %0d y %0d heading %0d",
                     got.pos_x, got.pos_y, got.heading);
        end else begin
          want = expected_results.pop_front();
          flag_field("pos_x", 64'(want.pos_x), 64'(got.pos_x));
          flag_field("pos_y", 64'(want.pos_y), 64'(got.pos_y));
          flag_field("heading", 64'(want.heading), 64'(got.heading));
          flag_field("target_found", 64'(want.target_found), 64'(got.target_found));
          flag_field("absorbed_now", 64'(want.absorbed_now), 64'(got.absorbed_now));
          flag_field("place_rejected", 64'(want.place_rejected),
                     64'(got.place_rejected));
          flag_field("wall_visits", 64'(want.wall_visits), 64'(got.wall_visits));
          flag_field("absorptions", 64'(want.absorptions), 64'(got.absorptions));
          if (want.place_rejected) rejects_seen++;
          if (want.absorbed_now) absorbs_seen++;
          results_checked++;
        end
      end
      results_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results in",
               cycle_count, results_checked, items_queued);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input logic [plws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [plws_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      plws_pkg::REG_FORWARD_PROB:  fwd_prob = val;
      plws_pkg::REG_REFLECT_PROB:  refl_prob = val;
      plws_pkg::REG_LATTICE_SIZE:  lat_size = val[plws_pkg::SIDE_W-1:0];
      plws_pkg::REG_BOUNDARY_MODE: bmode = val[plws_pkg::MODE_W-1:0];
      plws_pkg::REG_TARGET_X:      tgt_x = val[plws_pkg::POS_W-1:0];
      plws_pkg::REG_TARGET_Y:      tgt_y = val[plws_pkg::POS_W-1:0];
      plws_pkg::REG_DETECT_RADIUS: radius = val[plws_pkg::RAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic setup(input logic [plws_pkg::PROB_W-1:0] fp,
                       input logic [plws_pkg::PROB_W-1:0] rp,
                       input logic [plws_pkg::SIDE_W-1:0] sz,
                       input logic [plws_pkg::MODE_W-1:0] md,
                       input logic [plws_pkg::POS_W-1:0] tx,
                       input logic [plws_pkg::POS_W-1:0] ty,
                       input logic [plws_pkg::RAD_W-1:0] rad);
    write_reg(plws_pkg::REG_FORWARD_PROB, fp);
    write_reg(plws_pkg::REG_REFLECT_PROB, rp);
    write_reg(plws_pkg::REG_LATTICE_SIZE, 17'(sz));
    write_reg(plws_pkg::REG_BOUNDARY_MODE, 17'(md));
    write_reg(plws_pkg::REG_TARGET_X, 17'(tx));
    write_reg(plws_pkg::REG_TARGET_Y, 17'(ty));
    write_reg(plws_pkg::REG_DETECT_RADIUS, 17'(rad));
    setups_done++;
  endtask

  // Hold until every queued beat has come back checked
  task automatic drain();
    while (results_checked != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int k);
    case (k % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 81; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 81; end
      default: begin send_idle_pct = 29; stall_pct = 29; end
    endcase
  endtask

  function automatic void queue_item(plws_pkg::item_t it);
    pending_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_step(int draw, bit coin, int wdraw);
    plws_pkg::item_t it;
    it = '0;
    it.operation = plws_pkg::OP_STEP;
    it.move_draw = draw[plws_pkg::DRAW_W-1:0];
    it.turn_coin = coin;
    it.wall_draw = wdraw[plws_pkg::DRAW_W-1:0];
    queue_item(it);
  endfunction

  function automatic void queue_place(int x, int y, logic [plws_pkg::HEAD_W-1:0] h);
    plws_pkg::item_t it;
    it = '0;
    it.operation = plws_pkg::OP_PLACE;
    it.place_x = x[plws_pkg::POS_W-1:0];
    it.place_y = y[plws_pkg::POS_W-1:0];
    it.place_heading = h;
    queue_item(it);
  endfunction

  function automatic logic [plws_pkg::POS_W-1:0] random_coord(int side);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 10'(side - 1);
      2: return 10'($urandom_range(0, 1023));
      default: return 10'($urandom_range(0, side - 1));
    endcase
  endfunction

  // Random beat biased toward the decision edges and the lattice walls
  function automatic plws_pkg::item_t random_walk_item();
    plws_pkg::item_t it;
    int side;
    side = side_len();
    it.operation = ($urandom_range(0, 99) < 12) ? plws_pkg::OP_PLACE : plws_pkg::OP_STEP;
    case ($urandom_range(0, 5))
      0: it.move_draw = 16'(forward_limit() + $urandom_range(0, 2) - 1);
      1: it.move_draw = 16'(back_limit() + $urandom_range(0, 2) - 1);
      default: it.move_draw = 16'($urandom);
    endcase
    it.turn_coin = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) it.wall_draw = 16'(refl_prob + $urandom_range(0, 2) - 1);
    else it.wall_draw = 16'($urandom);
    it.place_x = random_coord(side);
    it.place_y = random_coord(side);
    it.place_heading = 2'($urandom_range(0, 3));
    return it;
  endfunction

  task automatic random_setup();
    logic [plws_pkg::PROB_W-1:0] fp;
    logic [plws_pkg::PROB_W-1:0] rp;
    logic [plws_pkg::SIDE_W-1:0] sz;
    logic [plws_pkg::MODE_W-1:0] md;
    logic [plws_pkg::POS_W-1:0] tx;
    logic [plws_pkg::POS_W-1:0] ty;
    logic [plws_pkg::RAD_W-1:0] rad;
    int side;
    case ($urandom_range(0, 5))
      0: fp = '0;
      1: fp = plws_pkg::PROB_ONE;
      2: fp = '1;
      default: fp = 17'($urandom_range(0, 65536));
    endcase
    case ($urandom_range(0, 5))
      0: rp = '0;
      1: rp = plws_pkg::PROB_ONE;
      2: rp = '1;
      default: rp = 17'($urandom_range(0, 65536));
    endcase
    case ($urandom_range(0, 9))
      0: sz = 11'($urandom_range(0, 1));
      1: sz = ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'h7FF;
      2: sz = 11'($urandom_range(2, 1024));
      default: sz = 11'($urandom_range(2, 16));
    endcase
    side = (sz < 2) ? 2 : (sz > 1024) ? 1024 : int'(sz);
    case ($urandom_range(0, 19))
      0: md = plws_pkg::MODE_FROZEN;
      1: md = plws_pkg::MODE_INERT;
      default: md = ($urandom_range(0, 1) != 0) ? plws_pkg::MODE_PERIODIC
                                                 : plws_pkg::MODE_ABSORB;
    endcase
    tx = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023)) :
                                       10'($urandom_range(0, side - 1));
    ty = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023)) :
                                       10'($urandom_range(0, side - 1));
    case ($urandom_range(0, 7))
      0: rad = 11'd2046;
      1: rad = '1;
      2: rad = 11'($urandom_range(0, 2047));
      default: rad = 11'($urandom_range(0, 3));
    endcase
    setup(fp, rp, sz, md, tx, ty, rad);
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_item(random_walk_item());
  endtask

  // Stimulus
  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_ch.valid = 1'b0;
    items_ch.data = '0;
    results_ch.ready = 1'b0;
    fwd_prob = 17'd32768;
    refl_prob = 17'd32768;
    lat_size = 11'd64;
    bmode = plws_pkg::MODE_PERIODIC;
    tgt_x = '0;
    tgt_y = '0;
    radius = '0;
    wk_x = '0;
    wk_y = '0;
    wk_head = plws_pkg::HEAD_RIGHT;
    bounce_count = '0;
    stuck_count = '0;
    items_queued = 0;
    results_checked = 0;
    mismatch_count = 0;
    cycle_count = 0;
    setups_done = 0;
    rejects_seen = 0;
    absorbs_seen = 0;
    set_idling(0);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Defaults after reset: periodic 64x64, straight/back/turn edges, wraps at the right and bottom sides
    queue_step(0, 1'b0, 0);
    queue_step(32768, 1'b0, 0);
    queue_step(43689, 1'b0, 0);
    queue_step(43690, 1'b1, 0);
    queue_step(65535, 1'b0, 0);
    queue_place(63, 63, plws_pkg::HEAD_RIGHT);
    queue_step(0, 1'b0, 0);
    queue_place(1023, 1023, plws_pkg::HEAD_UP);
    queue_step(0, 1'b0, 0);
    queue_place(0, 0, plws_pkg::HEAD_DOWN);
    queue_step(0, 1'b0, 0);
    queue_random(30);
    drain();

    // Absorbing walls on the smallest lattice, reflection always taken
    setup('0, plws_pkg::PROB_ONE, 11'd1, plws_pkg::MODE_ABSORB, 10'd1023, 10'd1023, 11'h7FF);
    queue_place(0, 0, plws_pkg::HEAD_RIGHT);
    queue_step(0, 1'b0, 0);
    queue_step(0, 1'b0, 65535);
    queue_place(1, 1, plws_pkg::HEAD_UP);
    queue_step(0, 1'b0, 0);
    queue_random(20);
    drain();

    // Largest lattice, never reflects, always straight
    setup(plws_pkg::PROB_ONE, '0, 11'h7FF, plws_pkg::MODE_ABSORB, 10'd500, 10'd500, '0);
    queue_place(1023, 500, plws_pkg::HEAD_UP);
    queue_step(0, 1'b0, 65535);
    queue_place(500, 0, plws_pkg::HEAD_LEFT);
    queue_step(0, 1'b0, 0);
    queue_place(500, 500, plws_pkg::HEAD_RIGHT);
    queue_step(65535, 1'b0, 0);
    queue_random(20);
    drain();

    // Frozen and inert walkers ignore steps but still take a placement
    setup('1, '1, 11'd16, plws_pkg::MODE_FROZEN, '0, '0, 11'd2046);
    queue_step(0, 1'b0, 0);
    queue_place(3, 3, plws_pkg::HEAD_DOWN);
    queue_step(65535, 1'b1, 65535);
    drain();
    setup(17'd32768, 17'd32768, 11'd8, plws_pkg::MODE_INERT, 10'd7, 10'd7, 11'd1);
    queue_step(0, 1'b0, 0);
    queue_place(7, 6, plws_pkg::HEAD_LEFT);
    queue_step(65535, 1'b1, 0);
    drain();

    // Random setups with rotating idle patterns
    for (int p = 0; p < 10; p++) begin
      random_setup();
      set_idling(p);
      queue_random(130);
      drain();
    end

    $display("checked %0d walker beats over %0d register setups", results_checked, setups_done);
    $display("placements rejected %0d, absorbing steps %0d, mismatches %0d",
             rejects_seen, absorbs_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
